// ===== rtl/dtfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared constants, status codes and the power-of-ten table for the decimal
// text to fixed point converter.
// ----------------------------------------------------------------------------
package dtfp_pkg;

    // default number of kept fraction digits
    localparam int DEFAULT_FRACTION_DIGITS = 6;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_RANGE     = 2'd2
    } status_t;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // powers of ten up to 10^9, enough for every supported digit count
    localparam int POW_W = 30;

    function automatic logic [POW_W-1:0] pow10_small(input logic [3:0] n);
        logic [POW_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/decimal_text_to_fixed_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Parses signed decimal text, one character per transfer, into a 32-bit
// value scaled by ten to the FRACTION_DIGITS.
// ----------------------------------------------------------------------------
// The block takes one character (or the end marker, sent with tlast high and
// no character) in every clock cycle while tready is high. Each character
// updates a running magnitude that is already scaled by ten to the
// FRACTION_DIGITS: an integer digit multiplies it by ten and adds the scaled
// digit, a kept fraction digit adds the digit times its place weight, so one
// character is one shift-add step and nothing is left to do at the end marker
// but a range compare and a negate. An end marker's result is registered into
// the output register, or into the skid register that backs it while the
// output is held, so input is stalled only while two results wait on the
// master side. Empty text gives 0; malformed text gives status 1, a magnitude
// beyond the 32-bit signed range gives status 2, and in both cases the value
// is 0. No clearing pass is needed after reset.
module decimal_text_to_fixed_point #(
    parameter int FRACTION_DIGITS = dtfp_pkg::DEFAULT_FRACTION_DIGITS
) (
    input  logic        clk,
    input  logic        rst_n,

    // character input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_text

    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] fixed_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import dtfp_pkg::*;

    // running magnitude saturates at 2^32, well above any valid result
    localparam int MAG_W = 33;
    localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [POW_W-1:0] SCALE = pow10_small(4'(FRACTION_DIGITS));
    localparam logic [3:0] FRAC_MAX = 4'(FRACTION_DIGITS);
    localparam logic [3:0] FRAC_TOP = 4'(FRACTION_DIGITS - 1);
    localparam logic [MAG_W-1:0] LIMIT_POS = 33'h0_7FFF_FFFF;
    localparam logic [MAG_W-1:0] LIMIT_NEG = 33'h0_8000_0000;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_INT   = 2'd1,
        PH_FRAC  = 2'd2
    } phase_t;

    // parser state
    phase_t           phase_reg,     phase_next;
    logic             negative_reg,  negative_next;
    logic [MAG_W-1:0] mag_reg,       mag_next;
    logic             int_seen_reg,  int_seen_next;
    logic [3:0]       frac_cnt_reg,  frac_cnt_next;
    logic             any_seen_reg,  any_seen_next;
    logic             error_reg,     error_next;

    // output register and skid register
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    status_t             out_status_reg;
    logic                skid_valid_reg;
    logic [VALUE_W-1:0]  skid_value_reg;
    status_t             skid_status_reg;

    logic                in_xfer;
    logic                out_xfer;
    logic                res_push;
    logic [CHAR_W-1:0]   ch;
    logic                is_digit;
    logic [3:0]          digit_val;
    logic [MAG_W+3:0]    int_sum;
    logic [MAG_W:0]      frac_sum;
    logic [MAG_W+3:0]    int_add;
    logic [POW_W+3:0]    frac_add;
    logic [MAG_W-1:0]    int_mag;
    logic [MAG_W-1:0]    frac_mag;
    logic [VALUE_W-1:0]  res_value;
    status_t             res_status;

    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = out_valid_reg && m_axis_tready;
    assign res_push = in_xfer && s_axis_tlast;

    // digit decode
    assign ch        = s_axis_tdata;
    assign is_digit  = ch inside {[CHAR_ZERO:CHAR_NINE]};
    assign digit_val = is_digit ? ch[3:0] : 4'd0;

    // integer digit: mag * 10 + digit * scale, saturated
    assign int_add  = (MAG_W+4)'(digit_val) * (MAG_W+4)'(SCALE);
    assign int_sum  = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + int_add;
    assign int_mag  = (int_sum > (MAG_W+4)'(MAG_CAP)) ? MAG_CAP : int_sum[MAG_W-1:0];

    // fraction digit: add digit times its place weight, saturated
    assign frac_add = (POW_W+4)'(digit_val) * (POW_W+4)'(pow10_small(FRAC_TOP - frac_cnt_reg));
    assign frac_sum = {1'b0, mag_reg} + (MAG_W+1)'(frac_add);
    assign frac_mag = (frac_sum > (MAG_W+1)'(MAG_CAP)) ? MAG_CAP : frac_sum[MAG_W-1:0];

    // next parser state
    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        mag_next      = mag_reg;
        int_seen_next = int_seen_reg;
        frac_cnt_next = frac_cnt_reg;
        any_seen_next = any_seen_reg;
        error_next    = error_reg;
        if (in_xfer)
        begin
            if (s_axis_tlast)
            begin
                phase_next    = PH_START;
                negative_next = 1'b0;
                mag_next      = '0;
                int_seen_next = 1'b0;
                frac_cnt_next = '0;
                any_seen_next = 1'b0;
                error_next    = 1'b0;
            end
            else
            begin
                any_seen_next = 1'b1;
                if (!error_reg)
                begin
                    case (phase_reg)
                        PH_START:
                        begin
                            if (ch == CHAR_SPACE)
                            begin
                                phase_next = PH_START;
                            end
                            else if (ch == CHAR_PLUS || ch == CHAR_MINUS)
                            begin
                                negative_next = (ch == CHAR_MINUS);
                                phase_next    = PH_INT;
                            end
                            else if (is_digit)
                            begin
                                mag_next      = int_mag;
                                int_seen_next = 1'b1;
                                phase_next    = PH_INT;
                            end
                            else if (ch == CHAR_DOT)
                            begin
                                phase_next = PH_FRAC;
                            end
                            else
                            begin
                                error_next = 1'b1;
                            end
                        end
                        PH_INT:
                        begin
                            if (is_digit)
                            begin
                                mag_next      = int_mag;
                                int_seen_next = 1'b1;
                            end
                            else if (ch == CHAR_DOT)
                            begin
                                phase_next = PH_FRAC;
                            end
                            else
                            begin
                                error_next = 1'b1;
                            end
                        end
                        PH_FRAC:
                        begin
                            if (is_digit)
                            begin
                                // digits past the kept ones are dropped
                                if (frac_cnt_reg < FRAC_MAX)
                                begin
                                    mag_next      = frac_mag;
                                    frac_cnt_next = frac_cnt_reg + 4'd1;
                                end
                            end
                            else
                            begin
                                error_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            error_next = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // result from the state at the end marker
    always_comb
    begin
        res_value  = '0;
        res_status = STATUS_OK;
        if (any_seen_reg)
        begin
            if (error_reg || !int_seen_reg || (phase_reg == PH_FRAC && frac_cnt_reg == 4'd0))
            begin
                res_status = STATUS_MALFORMED;
            end
            else if (mag_reg > (negative_reg ? LIMIT_NEG : LIMIT_POS))
            begin
                res_status = STATUS_RANGE;
            end
            else
            begin
                res_value = negative_reg ? (VALUE_W'(0) - mag_reg[VALUE_W-1:0])
                                         : mag_reg[VALUE_W-1:0];
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            negative_reg <= 1'b0;
            mag_reg      <= '0;
            int_seen_reg <= 1'b0;
            frac_cnt_reg <= '0;
            any_seen_reg <= 1'b0;
            error_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            mag_reg      <= mag_next;
            int_seen_reg <= int_seen_next;
            frac_cnt_reg <= frac_cnt_next;
            any_seen_reg <= any_seen_next;
            error_reg    <= error_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_xfer || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_push;
                end
            end
            else if (res_push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_xfer || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg  <= skid_value_reg;
                out_status_reg <= skid_status_reg;
            end
            else if (res_push)
            begin
                out_value_reg  <= res_value;
                out_status_reg <= res_status;
            end
        end
        else if (res_push)
        begin
            skid_value_reg  <= res_value;
            skid_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    // checks
    skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    frac_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frac_cnt_reg <= FRAC_MAX)
        else $error("fraction digit count beyond kept digits");

    mag_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg <= MAG_CAP)
        else $error("running magnitude above saturation cap");

    error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero value with an error status");

endmodule

// ===== tb/tb_decimal_text_to_fixed_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_fixed_point
// Self-checking regression for the decimal text to fixed point converter.
// Texts are streamed one character per transfer, each closed by an end
// marker. A behavioral parser in the bench tracks sign, integer magnitude and
// kept fraction digits and predicts value and status for every end marker.
// Directed texts hit range limits, signs, spaces and malformed forms, then
// random numbers, broken texts and a long output hold-off follow.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_fixed_point;
    import dtfp_pkg::*;

    localparam int  FRAC_DIGITS   = DEFAULT_FRACTION_DIGITS;
    localparam int  CLK_HALF      = 6;
    localparam int  RESET_CYCLES  = 6;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  IDLE_LIMIT    = 3000;
    localparam int  DRAIN_CYCLES  = 8;
    localparam int  MAX_REPORTS   = 10;
    localparam longint unsigned INT_CAP = 64'd4294967296;

    // parser phase of the bench's own model
    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } parse_phase_t;

    // receiver behavior between long hold-offs
    typedef enum int {
        READY_ALWAYS  = 0,
        READY_RANDOM  = 1,
        READY_PATTERN = 2
    } ready_mode_t;

    // ways of breaking a well-formed number
    typedef enum int {
        MUT_REPLACE = 0,
        MUT_INSERT  = 1,
        MUT_DROP    = 2,
        MUT_NOISE   = 3,
        MUT_APPEND  = 4
    } mutation_t;

    typedef struct {
        logic [31:0] value;
        status_t     status;
    } fixed_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_code
    logic        s_axis_tlast = 1'b0;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] fixed_value
    logic [1:0]  m_axis_tuser;          // [1:0] status

    // parser model state
    parse_phase_t    p_phase;
    logic            p_negative;
    longint unsigned p_int_mag;
    logic            p_int_digit;
    longint unsigned p_frac_val;
    int              p_frac_cnt;
    logic            p_any_char;
    logic            p_malformed;

    fixed_result_t   results_pending[$];
    logic [7:0]      text_buf[$];

    int items_sent;
    int texts_sent;
    int results_checked;
    int status_seen[3];
    int errors;
    int input_stall_cycles;
    int idle_cycles;
    int burst_left;
    bit sender_gaps = 1'b1;
    int hold_requests;

    decimal_text_to_fixed_point #(
        .FRACTION_DIGITS(FRAC_DIGITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic longint unsigned ten_pow(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++)
            p = p * 10;
        return p;
    endfunction

    task automatic clear_parser();
        p_phase     = PH_LEAD;
        p_negative  = 1'b0;
        p_int_mag   = 0;
        p_int_digit = 1'b0;
        p_frac_val  = 0;
        p_frac_cnt  = 0;
        p_any_char  = 1'b0;
        p_malformed = 1'b0;
    endtask

    // integer digit, magnitude saturates at 2^32
    task automatic add_int_digit(input logic [3:0] d);
        longint unsigned v;
        v = p_int_mag * 10 + d;
        p_int_mag   = (v > INT_CAP) ? INT_CAP : v;
        p_int_digit = 1'b1;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d = 4'(c - CHAR_ZERO);
        p_any_char = 1'b1;
        if (!p_malformed)
        begin
            case (p_phase)
                PH_LEAD:
                begin
                    if (c == CHAR_SPACE)
                    begin
                        // leading spaces are skipped
                    end
                    else if (c == CHAR_PLUS || c == CHAR_MINUS)
                    begin
                        p_negative = (c == CHAR_MINUS);
                        p_phase    = PH_INT;
                    end
                    else if (is_digit)
                    begin
                        add_int_digit(d);
                        p_phase = PH_INT;
                    end
                    else if (c == CHAR_DOT)
                        p_phase = PH_FRAC;
                    else
                        p_malformed = 1'b1;
                end
                PH_INT:
                begin
                    if (is_digit)
                        add_int_digit(d);
                    else if (c == CHAR_DOT)
                        p_phase = PH_FRAC;
                    else
                        p_malformed = 1'b1;
                end
                default:
                begin
                    if (!is_digit)
                        p_malformed = 1'b1;
                    else if (p_frac_cnt < FRAC_DIGITS)
                    begin
                        p_frac_val = p_frac_val * 10 + d;
                        p_frac_cnt++;
                    end
                end
            endcase
        end
    endtask

    // end marker: value and status, then back to the idle state
    task automatic parse_end(output fixed_result_t r);
        longint unsigned mag;
        longint unsigned lim;
        r.value  = 32'd0;
        r.status = STATUS_OK;
        if (p_any_char)
        begin
            if (p_malformed || !p_int_digit || (p_phase == PH_FRAC && p_frac_cnt == 0))
                r.status = STATUS_MALFORMED;
            else
            begin
                mag = p_int_mag * ten_pow(FRAC_DIGITS)
                    + p_frac_val * ten_pow(FRAC_DIGITS - p_frac_cnt);
                lim = p_negative ? 64'd2147483648 : 64'd2147483647;
                if (mag > lim)
                    r.status = STATUS_RANGE;
                else
                    r.value = p_negative ? (32'd0 - mag[31:0]) : mag[31:0];
            end
        end
        clear_parser();
    endtask

    // ------------------------------------------------------------------------
    // sender: bursts of transfers with random gaps
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] ch, input logic eot);
        int            gap;
        fixed_result_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0 || !sender_gaps) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
        if (eot)
        begin
            parse_end(r);
            results_pending.push_back(r);
        end
        else
            parse_char(ch);
    endtask

    // sends the buffered characters and closes the text
    task automatic send_buffered();
        foreach (text_buf[i])
            send_item(text_buf[i], 1'b0);
        send_item(8'($urandom), 1'b1);
        texts_sent++;
        text_buf.delete();
    endtask

    task automatic push_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        text_buf.delete();
        push_string(s);
        send_buffered();
    endtask

    function automatic logic [7:0] random_digit();
        return 8'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    // bias toward characters the parser cares about
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = CHAR_SPACE;
            1:       c = CHAR_PLUS;
            2:       c = CHAR_MINUS;
            3:       c = CHAR_DOT;
            4:       c = random_digit();
            default: c = 8'($urandom);
        endcase
        return c;
    endfunction

    // well-formed number with random content into the text buffer
    task automatic build_number();
        int sel;
        int n;
        text_buf.delete();
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back(CHAR_SPACE);
        sel = $urandom_range(0, 3);
        if (sel == 0)
            text_buf.push_back(CHAR_PLUS);
        else if (sel == 1)
            text_buf.push_back(CHAR_MINUS);
        // integer part, now and then close to the range limits
        sel = $urandom_range(0, 9);
        if (sel == 0)
            push_string("2147");
        else if (sel == 1)
            push_string("4294967");
        else
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            repeat (n) text_buf.push_back(random_digit());
        end
        // optional fraction, sometimes longer than what is kept
        if ($urandom_range(0, 2) != 0)
        begin
            text_buf.push_back(CHAR_DOT);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(FRAC_DIGITS + 1, FRAC_DIGITS + 4)
                                            : $urandom_range(1, FRAC_DIGITS);
            repeat (n) text_buf.push_back(random_digit());
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        send_text("");
        send_text("0");
        send_text("2147.483647");
        send_text("-2147.483648");
        send_text("2147.483648");
        send_text("-2147.483649");
        send_text("  +12.5");
        send_text("-0");
        send_text("-0.000001");
        send_text("1.1234567");
        send_text("1.1234567x");
        send_text("   ");
        send_text(".5");
        send_text("-");
        send_text("1.");
        send_text("1.2.3");
        send_text("1-2");
        send_text("1 2");
        send_text("++1");
        send_text("99999999999");
        send_text("99999999999x");
        // bytes with all bits set, no bits set and only the top bit set
        text_buf = {8'h31, 8'hFF};
        send_buffered();
        text_buf = {8'h00};
        send_buffered();
        text_buf = {8'h39, CHAR_DOT, 8'h80};
        send_buffered();
    endtask

    task automatic test_random_numbers(input int item_target);
        while (items_sent < item_target)
        begin
            build_number();
            send_buffered();
        end
    endtask

    task automatic test_random_malformed(input int item_target);
        while (items_sent < item_target)
        begin
            if ($urandom_range(0, 3) == 0)
                build_number();
            else
            begin
                case (mutation_t'($urandom_range(0, 4)))
                    MUT_REPLACE:
                    begin
                        build_number();
                        text_buf[$urandom_range(0, text_buf.size() - 1)] = noise_char();
                    end
                    MUT_INSERT:
                    begin
                        build_number();
                        text_buf.insert($urandom_range(0, text_buf.size()), noise_char());
                    end
                    MUT_DROP:
                    begin
                        build_number();
                        text_buf.delete($urandom_range(0, text_buf.size() - 1));
                    end
                    MUT_NOISE:
                    begin
                        text_buf.delete();
                        repeat ($urandom_range(0, 6)) text_buf.push_back(noise_char());
                    end
                    default:
                    begin
                        build_number();
                        text_buf.push_back(noise_char());
                    end
                endcase
            end
            send_buffered();
        end
    endtask

    // receiver holds off while short texts keep coming without gaps
    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        hold_requests++;
        repeat (40)
        begin
            text_buf.delete();
            repeat ($urandom_range(1, 2)) text_buf.push_back(random_digit());
            send_buffered();
        end
        sender_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // receiver stall pattern
    // ------------------------------------------------------------------------
    ready_mode_t rx_mode;
    int          rx_mode_left;
    int          rx_hold_left;
    int          rx_hold_seen;
    logic [7:0]  rx_pattern;

    always @(posedge clk)
    begin
        if (hold_requests != rx_hold_seen)
        begin
            rx_hold_seen = hold_requests;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = ready_mode_t'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(16, 96);
                rx_pattern   = 8'($urandom_range(1, 255));
            end
            rx_mode_left--;
            case (rx_mode)
                READY_ALWAYS:  m_axis_tready <= 1'b1;
                READY_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
                default:
                begin
                    m_axis_tready <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        fixed_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: value %0d status %0d",
                             $signed(m_axis_tdata), m_axis_tuser);
            end
            else
            begin
                want = results_pending.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (m_axis_tdata !== want.value || m_axis_tuser !== want.status)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch on result %0d: expected %0d/%0d, got %0d/%0d",
                                 results_checked, $signed(want.value), want.status,
                                 $signed(m_axis_tdata), m_axis_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog on cycles with no transfer on either side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (s_axis_tvalid && !s_axis_tready)
            input_stall_cycles++;
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("decimal_text_to_fixed_point regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_numbers(620);
        test_random_malformed(820);
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        while (results_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d transfers in %0d texts, checked %0d results",
                 items_sent, texts_sent, results_checked);
        $display("(%0d ok, %0d malformed, %0d out of range), input held back %0d cycles",
                 status_seen[STATUS_OK], status_seen[STATUS_MALFORMED],
                 status_seen[STATUS_RANGE], input_stall_cycles);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("decimal_text_to_fixed_point regression: pass");
        else
            $display("decimal_text_to_fixed_point regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dtfp_pkg.sv
rtl/decimal_text_to_fixed_point.sv
tb/tb_decimal_text_to_fixed_point.sv
